>>> hw/rtl/sha1md_pkg.sv
package sha1md_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WORDS   = 5;
   localparam int unsigned BLOCK_W = 512;
   localparam int unsigned ROUNDS  = 80;

   localparam logic [WORD_W-1:0] K_ROUND [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [WORD_W-1:0] INIT_WORD [WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [7:0] PAD_MARK   = 8'h80;
   // Fill position at which the length field begins (byte 56 of a block).
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_MARK,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   typedef enum logic [1:0] {
      F_CHOOSE,
      F_PARITY_A,
      F_MAJORITY,
      F_PARITY_B
   } round_fn_type;

   typedef struct packed {
      logic         push;
      byte_src_type src;
      logic         load_vars;
      logic         round_en;
      round_fn_type fn;
      logic         add_chain;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } dp_sts_type;

endpackage

>>> hw/rtl/sha1md_ctrl.sv
module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD_ONE,
      S_PAD_ZERO,
      S_PAD_LEN,
      S_ROUND,
      S_ADD,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [6:0] round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       wrap;

   assign wrap      = (sts.fill == LAST_SLOT);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      round_in      = round_ff;
      cmd           = '0;
      cmd.src       = SRC_INPUT;
      cmd.fn        = F_CHOOSE;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.push = 1'b1;
                  if (wrap) begin
                     cmd.load_vars = 1'b1;
                     state_in      = S_ROUND;
                     ret_in        = req_last ? S_PAD_ONE : S_IDLE;
                  end else if (req_last) begin
                     state_in = S_PAD_ONE;
                  end
               end else if (req_last) begin
                  state_in = S_PAD_ONE;
               end
            end
         end
         S_PAD_ONE: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_MARK;
            if (wrap) begin
               cmd.load_vars = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_PAD_ZERO;
            end else begin
               state_in = S_PAD_ZERO;
            end
         end
         S_PAD_ZERO: begin
            if (sts.fill == LEN_OFFSET) begin
               state_in = S_PAD_LEN;
            end else begin
               cmd.push = 1'b1;
               cmd.src  = SRC_ZERO;
               if (wrap) begin
                  cmd.load_vars = 1'b1;
                  state_in      = S_ROUND;
                  ret_in        = S_PAD_ZERO;
               end
            end
         end
         S_PAD_LEN: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LENGTH;
            if (wrap) begin
               cmd.load_vars = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_DONE;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff < 7'd20) begin
               cmd.fn = F_CHOOSE;
            end else if (round_ff < 7'd40) begin
               cmd.fn = F_PARITY_A;
            end else if (round_ff < 7'd60) begin
               cmd.fn = F_MAJORITY;
            end else begin
               cmd.fn = F_PARITY_B;
            end
            if (round_ff == 7'(ROUNDS - 1)) begin
               round_in = '0;
               state_in = S_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         S_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = ret_ff;
         end
         S_DONE: begin
            // Wait for the output register to be free before re-initialising.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/sha1md_dp.sv
module sha1md_dp
   import sha1md_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [7:0]        data_byte,
   output dp_sts_type        sts,
   output logic [WORD_W-1:0] digest [WORDS]
);

   logic [BLOCK_W-1:0] window_ff, window_in;
   logic [WORD_W-1:0]  chain_ff [WORDS];
   logic [WORD_W-1:0]  vars_ff  [WORDS];
   logic [WORD_W-1:0]  digest_ff [WORDS];
   logic [63:0]        bits_ff;
   logic [5:0]         fill_ff;
   logic [7:0]         push_byte;
   logic [7:0]         len_byte;
   logic [WORD_W-1:0]  w0, w2, w8, w13, w_mix, w_new;
   logic [WORD_W-1:0]  f_val, k_val, t_val;
   logic [WORD_W-1:0]  va, vb, vc, vd, ve;

   assign sts.fill = fill_ff;

   // The length bytes go out most significant first, at fill positions 56 to 63.
   assign len_byte = 8'(bits_ff >> {~fill_ff[2:0], 3'b000});

   always_comb begin
      case (cmd.src)
         SRC_INPUT:  push_byte = data_byte;
         SRC_MARK:   push_byte = PAD_MARK;
         SRC_ZERO:   push_byte = 8'h00;
         SRC_LENGTH: push_byte = len_byte;
         default:    push_byte = 8'h00;
      endcase
   end

   // The window holds the sixteen newest schedule words, the oldest at the top.
   assign w0    = window_ff[BLOCK_W-1      -: WORD_W];
   assign w2    = window_ff[BLOCK_W-1-2*32 -: WORD_W];
   assign w8    = window_ff[BLOCK_W-1-8*32 -: WORD_W];
   assign w13   = window_ff[BLOCK_W-1-13*32 -: WORD_W];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {w_mix[30:0], w_mix[31]};

   assign va = vars_ff[0];
   assign vb = vars_ff[1];
   assign vc = vars_ff[2];
   assign vd = vars_ff[3];
   assign ve = vars_ff[4];

   always_comb begin
      case (cmd.fn)
         F_CHOOSE: begin
            f_val = (vb & vc) | (~vb & vd);
            k_val = K_ROUND[0];
         end
         F_PARITY_A: begin
            f_val = vb ^ vc ^ vd;
            k_val = K_ROUND[1];
         end
         F_MAJORITY: begin
            f_val = (vb & vc) | (vb & vd) | (vc & vd);
            k_val = K_ROUND[2];
         end
         F_PARITY_B: begin
            f_val = vb ^ vc ^ vd;
            k_val = K_ROUND[3];
         end
         default: begin
            f_val = vb ^ vc ^ vd;
            k_val = K_ROUND[3];
         end
      endcase
   end

   assign t_val = {va[26:0], va[31:27]} + f_val + ve + k_val + w0;

   always_comb begin
      window_in = window_ff;
      if (cmd.push) begin
         window_in = {window_ff[BLOCK_W-9:0], push_byte};
      end else if (cmd.round_en) begin
         window_in = {window_ff[BLOCK_W-WORD_W-1:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (cmd.load_vars) begin
         for (int i = 0; i < WORDS; i++) begin
            vars_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         vars_ff[0] <= t_val;
         vars_ff[1] <= va;
         vars_ff[2] <= {vb[1:0], vb[31:2]};
         vars_ff[3] <= vc;
         vars_ff[4] <= vd;
      end
      if (cmd.out_load) begin
         for (int i = 0; i < WORDS; i++) begin
            digest_ff[i] <= chain_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            chain_ff[i] <= INIT_WORD[i];
         end
         bits_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.out_load) begin
            for (int i = 0; i < WORDS; i++) begin
               chain_ff[i] <= INIT_WORD[i];
            end
            bits_ff <= '0;
            fill_ff <= '0;
         end else begin
            if (cmd.add_chain) begin
               for (int i = 0; i < WORDS; i++) begin
                  chain_ff[i] <= chain_ff[i] + vars_ff[i];
               end
            end
            if (cmd.push) begin
               fill_ff <= fill_ff + 6'd1;
               if (cmd.src == SRC_INPUT) begin
                  bits_ff <= bits_ff + 64'd8;
               end
            end
         end
      end
   end

   assign digest = digest_ff;

endmodule

>>> hw/rtl/sha1_message_digest.sv
// Channel  Direction  Handshake            Words
// req      in         req_valid/req_stall  req_data_byte, req_has_byte, req_last
// rsp      out        rsp_valid/rsp_stall  rsp_digest_word0 .. rsp_digest_word4
//
// A byte word is taken while req_stall is low; the word that completes a 64-byte
// block is followed by compression (80 rounds of the single round unit, then one
// chaining add), during which req_stall is high.
// A word with last is followed by the mark byte, zero bytes, a check state,
// the length bytes, a compression per filled block and the digest load.
// Synchronous reset loads the initial chaining words; no clearing pass is needed.
// The digest sits in an output register, so a stalled result does not block new
// bytes; only the end of the next message waits for it to be taken.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [WORD_W-1:0] digest [WORDS];

   sha1md_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_has_byte (req_has_byte),
      .req_last     (req_last),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   sha1md_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_data_byte),
      .sts       (sts),
      .digest    (digest)
   );

   assign rsp_digest_word0 = digest[0];
   assign rsp_digest_word1 = digest[1];
   assign rsp_digest_word2 = digest[2];
   assign rsp_digest_word3 = digest[3];
   assign rsp_digest_word4 = digest[4];

`ifndef NO_ASSERTIONS
   // A compression starts only with the byte that completes a block.
   a_load_on_wrap : assert property (@(posedge clock) disable iff (reset)
      cmd.load_vars |-> (cmd.push && sts.fill == LAST_SLOT))
      else $error("compression started on a partial block");

   // A digest is released only on a block boundary.
   a_out_aligned : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (sts.fill == 6'd0))
      else $error("digest released with bytes in the buffer");

   // Byte shifting and round shifting never share a cycle.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.round_en))
      else $error("byte push during a compression round");

   // No byte word is taken while a compression is running.
   a_stall_in_rounds : assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> req_stall)
      else $error("input open during compression");
`endif

endmodule
